@@ src/pip_pkg.sv @@
// ---------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Holds the controller state type, the command bundle passed from the
// controller to the datapath, and the fixed field widths.
// ---------------------------------------------------------------------------
package pip_pkg;

  localparam int MAX_VERTICES_DEF = 64;

  localparam int COORD_W = 16;
  localparam int INDEX_W = 6;
  localparam int COUNT_W = 7;
  localparam int VCOUNT_W = 7;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 7'd3;
  localparam int VCOUNT_MIN = 3;

  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_EDGE,
    ST_DRAIN,
    ST_DONE
  } pip_state_t;

  typedef struct packed {
    logic wr_en;
    logic start;
    logic rd_en;
    logic rd_max;
    logic rd_first;
    logic out_load;
  } pip_cmd_t;

endpackage

@@ src/pip_ram.sv @@
// ---------------------------------------------------------------------------
// pip_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module pip_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/pip_ctrl.sv @@
// ---------------------------------------------------------------------------
// pip_ctrl: sequencer for the point-in-polygon test
// Holds the vertex count register, walks the vertex store once for the
// maximum y and once for the edges, and owns the result valid flag.
// ---------------------------------------------------------------------------
module pip_ctrl #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              func,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  input  logic                              cfg_wr_en,
  input  logic [pip_pkg::VCOUNT_W-1:0]      cfg_wr_data,
  input  logic                              busy,
  output pip_pkg::pip_cmd_t                 cmd,
  output logic [$clog2(MAX_VERTICES)-1:0]   rd_addr
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  pip_pkg::pip_state_t state, state_next;
  logic [pip_pkg::VCOUNT_W-1:0] vertex_count;
  logic [NW-1:0] n;
  logic [NW-1:0] idx, idx_next;
  logic accept;

  assign in_stall = (state != pip_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Vertex count clamped to the range the store supports.
  always_comb begin
    if (32'(vertex_count) > MAX_VERTICES) begin
      n = NW'(MAX_VERTICES);
    end else if (32'(vertex_count) < pip_pkg::VCOUNT_MIN) begin
      n = NW'(pip_pkg::VCOUNT_MIN);
    end else begin
      n = NW'(vertex_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= pip_pkg::ST_IDLE;
      vertex_count <= pip_pkg::VCOUNT_RESET;
      idx          <= '0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      if (cfg_wr_en) begin
        vertex_count <= cfg_wr_data;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pip_pkg::ST_IDLE: begin
        if (accept && func == pip_pkg::FUNC_QUERY) begin
          state_next = pip_pkg::ST_MAX;
        end
      end
      pip_pkg::ST_MAX: begin
        if (idx == n - NW'(1)) begin
          state_next = pip_pkg::ST_EDGE;
        end
      end
      pip_pkg::ST_EDGE: begin
        if (idx == n) begin
          state_next = pip_pkg::ST_DRAIN;
        end
      end
      pip_pkg::ST_DRAIN: begin
        if (!busy) begin
          state_next = pip_pkg::ST_DONE;
        end
      end
      pip_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          state_next = pip_pkg::ST_IDLE;
        end
      end
      default: state_next = pip_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    idx_next = '0;
    case (state)
      pip_pkg::ST_MAX:  idx_next = (idx == n - NW'(1)) ? '0 : idx + NW'(1);
      pip_pkg::ST_EDGE: idx_next = idx + NW'(1);
      default:          idx_next = '0;
    endcase
  end

  always_comb begin
    cmd     = '0;
    rd_addr = '0;
    case (state)
      pip_pkg::ST_IDLE: begin
        cmd.start = accept && func == pip_pkg::FUNC_QUERY;
        cmd.wr_en = accept && func == pip_pkg::FUNC_WRITE;
      end
      pip_pkg::ST_MAX: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_max   = 1'b1;
        cmd.rd_first = (idx == '0);
        rd_addr      = AW'(idx);
      end
      pip_pkg::ST_EDGE: begin
        // The last read fetches vertex zero again to close the polygon.
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (idx == '0);
        rd_addr      = (idx == n) ? '0 : AW'(idx);
      end
      pip_pkg::ST_DONE: begin
        cmd.out_load = !out_valid || !out_stall;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

@@ src/pip_dp.sv @@
// ---------------------------------------------------------------------------
// pip_dp: datapath of the point-in-polygon test
// Vertex store, maximum-y tracker, a three-stage crossing pipeline
// (differences, products, sign test) and the result register.
// ---------------------------------------------------------------------------
module pip_dp #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  pip_pkg::pip_cmd_t                      cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]        rd_addr,
  input  logic [pip_pkg::INDEX_W-1:0]            vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0]     coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0]     coord_y,
  output logic                                   busy,
  output logic                                   inside_res,
  output logic [pip_pkg::COUNT_W-1:0]            crossings
);

  localparam int AW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int CWD = pip_pkg::COORD_W;
  localparam int OUT_W = pip_pkg::COUNT_W;

  logic ram_we;
  logic [2*CWD-1:0] rdata;
  logic signed [CWD-1:0] rx, ry;

  logic signed [CWD-1:0] cx, cy;
  logic signed [CWD-1:0] maxy;
  logic signed [CWD:0]   top;
  logic signed [CWD-1:0] prev_x, prev_y;

  logic rv, rmax, rfirst;
  logic av, a_strad;
  logic signed [CWD:0]   dx, dy, ex, f1;
  logic signed [CWD+1:0] f2;
  logic bv, b_strad;
  logic signed [2*CWD+1:0] p1, p3;
  logic signed [2*CWD+2:0] p2;
  logic signed [2*CWD+3:0] tc, td;
  logic hit;
  logic [CW-1:0] cnt;

  assign ram_we = cmd.wr_en && (32'(vertex_index) < MAX_VERTICES);

  pip_ram #(
    .WIDTH(2 * CWD),
    .DEPTH(MAX_VERTICES)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(vertex_index)),
    .wdata({coord_x, coord_y}),
    .re   (cmd.rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  assign rx  = rdata[2*CWD-1:CWD];
  assign ry  = rdata[CWD-1:0];
  assign top = (CWD+1)'(maxy) + (CWD+1)'(1);

  // The probe is vertical, so it meets an edge's line on opposite sides only
  // when the edge straddles the probe's x strictly and the probe has length.
  // The remaining test is the sign of the edge's cross product at both ends.
  assign tc  = (2*CWD+4)'(p1) + (2*CWD+4)'(p3);
  assign td  = (2*CWD+4)'(p2) + (2*CWD+4)'(p3);
  assign hit = bv && b_strad && (tc[2*CWD+3] != td[2*CWD+3]) && (tc != '0) && (td != '0);

  assign busy = rv || av || bv;

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
      av <= 1'b0;
      bv <= 1'b0;
    end else begin
      rv <= cmd.rd_en;
      av <= rv && !rmax && !rfirst;
      bv <= av;
    end
  end

  always_ff @(posedge clk) begin
    rmax   <= cmd.rd_max;
    rfirst <= cmd.rd_first;

    if (cmd.start) begin
      cx <= coord_x;
      cy <= coord_y;
    end

    if (rv && rmax && (rfirst || ry > maxy)) begin
      maxy <= ry;
    end

    if (rv && !rmax) begin
      prev_x  <= rx;
      prev_y  <= ry;
      dx      <= (CWD+1)'(prev_x) - (CWD+1)'(rx);
      dy      <= (CWD+1)'(prev_y) - (CWD+1)'(ry);
      ex      <= (CWD+1)'(prev_x) - (CWD+1)'(cx);
      f1      <= (CWD+1)'(cy) - (CWD+1)'(prev_y);
      f2      <= (CWD+2)'(top) - (CWD+2)'(prev_y);
      a_strad <= ((prev_x < cx && cx < rx) || (rx < cx && cx < prev_x))
                 && ((CWD+1)'(cy) != top);
    end

    p1      <= dx * f1;
    p2      <= dx * f2;
    p3      <= dy * ex;
    b_strad <= a_strad;

    if (cmd.start) begin
      cnt <= '0;
    end else if (hit) begin
      cnt <= cnt + CW'(1);
    end

    if (cmd.out_load) begin
      inside_res <= cnt[0];
      crossings  <= OUT_W'(cnt);
    end
  end

endmodule

@@ src/point_in_polygon_test.sv @@
// ---------------------------------------------------------------------------
// point_in_polygon_test: vertical ray-crossing point-in-polygon test
// Loads polygon vertices into a store and answers point queries with the
// number of strictly crossed edges and an odd-parity inside flag.
// ---------------------------------------------------------------------------
//
//   channel   handshake                 payload
//   input     in_valid / in_stall       func, vertex_index, coord_x, coord_y
//   output    out_valid / out_stall     inside_res, crossings
//   config    cfg_wr_en                 cfg_wr_data (vertex count)
//
// After a vertex write the block is ready again at once.
// A query with n vertices makes one read of the vertex store per cycle
// for the maximum y, then n + 1 reads for the edges, then drains the
// crossing pipeline and loads the result register.
// Reset is synchronous and clears control state; the vertex store is not
// cleared. A stalled result is held in the output register while the next
// item is taken; a finished query waits only if that register is still full.
module point_in_polygon_test #(
  parameter int MAX_VERTICES = pip_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               func,
  input  logic [pip_pkg::INDEX_W-1:0]        vertex_index,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               inside_res,
  output logic [pip_pkg::COUNT_W-1:0]        crossings,
  input  logic                               cfg_wr_en,
  input  logic [pip_pkg::VCOUNT_W-1:0]       cfg_wr_data
);

  pip_pkg::pip_cmd_t cmd;
  logic [$clog2(MAX_VERTICES)-1:0] rd_addr;
  logic busy;

  pip_ctrl #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .func       (func),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .busy       (busy),
    .cmd        (cmd),
    .rd_addr    (rd_addr)
  );

  pip_dp #(
    .MAX_VERTICES(MAX_VERTICES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .vertex_index(vertex_index),
    .coord_x     (coord_x),
    .coord_y     (coord_y),
    .busy        (busy),
    .inside_res  (inside_res),
    .crossings   (crossings)
  );

  // An accepted query always occupies the block for the following cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == pip_pkg::FUNC_QUERY |=> in_stall)
    else $error("query transfer did not start a walk");

  // A vertex write never holds off the next item.
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && func == pip_pkg::FUNC_WRITE |=> !in_stall)
    else $error("vertex write stalled the input");

  // A result only appears at the end of a query walk.
  a_result_from_walk: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a query in progress");

  // The inside flag is the parity of the crossing count.
  a_parity: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> inside_res == crossings[0])
    else $error("inside flag disagrees with crossing parity");

endmodule
